/* rtl/core/hgrp_pkg.sv */
package hgrp_pkg;

	localparam int REQUEST_BYTES_DEF = 4096;
	localparam int PATH_BYTES_DEF    = 256;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2e;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_BAD  = 2'd1;
	localparam logic [1:0] STATUS_LONG = 2'd2;

	localparam logic [2:0] CT_PLAIN = 3'd0;
	localparam logic [2:0] CT_HTML  = 3'd1;
	localparam logic [2:0] CT_PNG   = 3'd2;
	localparam logic [2:0] CT_JPEG  = 3'd3;
	localparam logic [2:0] CT_GIF   = 3'd4;
	localparam logic [2:0] CT_CSS   = 3'd5;
	localparam logic [2:0] CT_JS    = 3'd6;
	localparam logic [2:0] CT_OCTET = 3'd7;

	localparam logic KIND_PATH    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	typedef enum logic [2:0] {
		ST_METHOD,
		ST_URI_FIRST,
		ST_URI,
		ST_VERSION,
		ST_HEADER,
		ST_DONE
	} stage_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       request_end;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] path_byte;
		logic [1:0] status;
		logic [2:0] content_type;
		logic       default_index;
		logic [7:0] path_length;
	} res_t;

	// Expected byte of "GET "
	function automatic logic [7:0] method_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = "G";
			2'd1:    c = "E";
			2'd2:    c = "T";
			default: c = CH_SP;
		endcase
		return c;
	endfunction

	// Expected byte of "HTTP/1.x"; minor selects the last digit
	function automatic logic [7:0] version_char(input logic [2:0] idx, input logic minor);
		logic [7:0] c;
		case (idx)
			3'd0:    c = "H";
			3'd1:    c = "T";
			3'd2:    c = "T";
			3'd3:    c = "P";
			3'd4:    c = "/";
			3'd5:    c = "1";
			3'd6:    c = ".";
			default: c = minor ? "1" : "0";
		endcase
		return c;
	endfunction

	// Map the text after the last dot to a content type
	function automatic logic [2:0] content_code(input logic dot, input logic [2:0] len,
			input logic [3:0][7:0] chars);
		logic [15:0] t2;
		logic [23:0] t3;
		logic [31:0] t4;
		logic [2:0]  ct;
		t2 = {chars[0], chars[1]};
		t3 = {chars[0], chars[1], chars[2]};
		t4 = {chars[0], chars[1], chars[2], chars[3]};
		ct = CT_OCTET;
		if (!dot) begin
			ct = CT_PLAIN;
		end else if (len == 3'd4) begin
			if (t4 == "html")
				ct = CT_HTML;
			else if (t4 == "jpeg")
				ct = CT_JPEG;
		end else if (len == 3'd3) begin
			case (t3)
				"htm":   ct = CT_HTML;
				"txt":   ct = CT_PLAIN;
				"png":   ct = CT_PNG;
				"jpg":   ct = CT_JPEG;
				"gif":   ct = CT_GIF;
				"css":   ct = CT_CSS;
				default: ct = CT_OCTET;
			endcase
		end else if (len == 3'd2) begin
			if (t2 == "js")
				ct = CT_JS;
		end
		return ct;
	endfunction

endpackage

/* rtl/core/hgrp_stream_if.sv */
interface hgrp_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/hgrp_parser.sv */
module hgrp_parser #(
	parameter int REQUEST_BYTES = hgrp_pkg::REQUEST_BYTES_DEF,
	parameter int PATH_BYTES    = hgrp_pkg::PATH_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  hgrp_pkg::req_t  req,
	output logic            res_vld,
	output hgrp_pkg::res_t  res
);
	import hgrp_pkg::*;

	localparam int RCW = $clog2(REQUEST_BYTES);
	localparam int PCW = $clog2(PATH_BYTES + 1);
	localparam int PLW = (PCW > 8) ? PCW : 8;
	localparam logic [RCW-1:0] RC_LAST = RCW'(REQUEST_BYTES - 1);
	localparam logic [PCW-1:0] PC_MAX  = PCW'(PATH_BYTES - 1);
	localparam logic [PCW-1:0] PC_FULL = PCW'(PATH_BYTES);

	stage_t          stage_q, stage_d;
	logic [3:0]      midx_q, midx_d;
	logic [1:0]      vflags_q, vflags_d, vflags_n;
	logic [1:0]      term_q, term_d;
	logic            lf_q, lf_d;
	logic [RCW-1:0]  rcnt_q, rcnt_d;
	logic [PCW-1:0]  pcnt_q, pcnt_d;
	logic [3:0][7:0] ext_q, ext_d;
	logic            dot_q, dot_d;
	logic [2:0]      elen_q, elen_d;

	logic            verdict, emit_path;
	logic [1:0]      vstatus;
	logic [PCW-1:0]  emitted;
	logic [PLW-1:0]  emitted_x;
	logic [7:0]      b;

	assign b = req.data_byte;

	// Hold the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= ST_METHOD;
			midx_q   <= '0;
			vflags_q <= 2'b11;
			term_q   <= '0;
			lf_q     <= 1'b0;
			rcnt_q   <= '0;
			pcnt_q   <= '0;
			ext_q    <= '0;
			dot_q    <= 1'b0;
			elen_q   <= '0;
		end else if (step) begin
			stage_q  <= stage_d;
			midx_q   <= midx_d;
			vflags_q <= vflags_d;
			term_q   <= term_d;
			lf_q     <= lf_d;
			rcnt_q   <= rcnt_d;
			pcnt_q   <= pcnt_d;
			ext_q    <= ext_d;
			dot_q    <= dot_d;
			elen_q   <= elen_d;
		end
	end

	// Advance the parser by one byte
	always_comb begin
		stage_d   = stage_q;
		midx_d    = midx_q;
		vflags_d  = vflags_q;
		term_d    = term_q;
		lf_d      = lf_q;
		rcnt_d    = rcnt_q;
		pcnt_d    = pcnt_q;
		ext_d     = ext_q;
		dot_d     = dot_q;
		elen_d    = elen_q;
		vflags_n  = vflags_q & {b == version_char(midx_q[2:0], 1'b0),
				b == version_char(midx_q[2:0], 1'b1)};
		verdict   = 1'b0;
		emit_path = 1'b0;
		vstatus   = STATUS_BAD;

		if (stage_q != ST_DONE) begin
			if (rcnt_q >= RC_LAST || b == CH_NUL) begin
				verdict = 1'b1;
			end else begin
				unique case (stage_q)
					ST_METHOD: begin
						if (midx_q > 4'd3 || b != method_char(midx_q[1:0])) begin
							verdict = 1'b1;
						end else begin
							midx_d = midx_q + 4'd1;
							if (midx_q == 4'd3)
								stage_d = ST_URI_FIRST;
						end
					end
					ST_URI_FIRST: begin
						if (b == CH_SP || b == CH_CR || b == CH_LF)
							verdict = 1'b1;
						else
							stage_d = ST_URI;
					end
					ST_URI: begin
						if (b == CH_SP) begin
							stage_d  = ST_VERSION;
							midx_d   = '0;
							vflags_d = 2'b11;
						end else if (b == CH_CR || b == CH_LF) begin
							verdict = 1'b1;
						end else if (pcnt_q < PC_MAX) begin
							pcnt_d    = pcnt_q + PCW'(1);
							emit_path = 1'b1;
							if (b == CH_DOT) begin
								dot_d  = 1'b1;
								elen_d = '0;
							end else if (dot_q) begin
								if (elen_q < 3'd4)
									ext_d[elen_q[1:0]] = b;
								if (elen_q < 3'd5)
									elen_d = elen_q + 3'd1;
							end
						end else begin
							pcnt_d = PC_FULL;
						end
					end
					ST_VERSION: begin
						if (midx_q >= 4'd8) begin
							if (b == CH_CR) begin
								stage_d = ST_HEADER;
								term_d  = 2'd1;
								lf_d    = 1'b0;
							end else begin
								verdict = 1'b1;
							end
						end else begin
							vflags_d = vflags_n;
							if (vflags_n == 2'b00)
								verdict = 1'b1;
							else
								midx_d = midx_q + 4'd1;
						end
					end
					ST_HEADER: begin
						if (b == CH_LF) begin
							if (lf_q || term_q == 2'd3) begin
								verdict = 1'b1;
								vstatus = (pcnt_q >= PC_FULL) ? STATUS_LONG : STATUS_OK;
							end else begin
								term_d = (term_q == 2'd1) ? 2'd2 : 2'd0;
								lf_d   = 1'b1;
							end
						end else if (b == CH_CR) begin
							term_d = (term_q == 2'd2) ? 2'd3 : 2'd1;
							lf_d   = 1'b0;
						end else begin
							term_d = 2'd0;
							lf_d   = 1'b0;
						end
					end
					ST_DONE: ;
					default: ;
				endcase
			end
			if (rcnt_q < RC_LAST)
				rcnt_d = rcnt_q + RCW'(1);
		end

		if (verdict)
			stage_d = ST_DONE;

		// Close the connection: force a verdict if none was given
		if (req.request_end && stage_d != ST_DONE) begin
			verdict   = 1'b1;
			vstatus   = STATUS_BAD;
			emit_path = 1'b0;
		end

		emitted   = (pcnt_d < PC_MAX) ? pcnt_d : PC_MAX;
		emitted_x = PLW'(emitted);

		res_vld           = step && (verdict || emit_path);
		res.kind          = verdict ? KIND_VERDICT : KIND_PATH;
		res.path_byte     = verdict ? 8'd0 : b;
		res.status        = verdict ? vstatus : STATUS_OK;
		res.content_type  = CT_PLAIN;
		res.default_index = 1'b0;
		res.path_length   = verdict ? emitted_x[7:0] : 8'd0;
		if (verdict && vstatus == STATUS_OK) begin
			if (pcnt_d == '0) begin
				res.default_index = 1'b1;
				res.content_type  = CT_HTML;
			end else begin
				res.content_type = content_code(dot_q, elen_q, ext_q);
			end
		end

		// Return to reset values after the last byte
		if (req.request_end) begin
			stage_d  = ST_METHOD;
			midx_d   = '0;
			vflags_d = 2'b11;
			term_d   = '0;
			lf_d     = 1'b0;
			rcnt_d   = '0;
			pcnt_d   = '0;
			ext_d    = '0;
			dot_d    = 1'b0;
			elen_d   = '0;
		end
	end

endmodule

/* rtl/core/http_get_request_parser_top.sv */
// Channel | Dir | Payload                                                    | Handshake
// req     | in  | data_byte, request_end                                     | valid/ready
// res     | out | kind, path_byte, status, content_type, default_index,     | valid/ready
//         |     | path_length                                                |
//
// One byte per cycle sustained while the result side is ready. A byte enters the input register
// at the edge that accepts it; its result, if any, is loaded into the result register when the
// parser steps on that byte, which a stalled result can hold back, and is offered from there.
// Throughput is set by the byte step of the parser state machine.
// arst_n clears all control state at once; the block is ready right after reset.
// A stalled result holds the parser; bytes that make no result still pass only
// when the result register is free or being drained.
module http_get_request_parser_top #(
	parameter int REQUEST_BYTES = hgrp_pkg::REQUEST_BYTES_DEF,
	parameter int PATH_BYTES    = hgrp_pkg::PATH_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	hgrp_stream_if.sink   req,
	hgrp_stream_if.source res
);
	import hgrp_pkg::*;

	req_t req_s1;
	logic vld_s1;
	logic adv;
	logic core_vld;
	res_t core_res;
	res_t res_q;
	logic res_vld_q;

	// Move the held byte through the parser when the result slot can take it
	assign adv       = vld_s1 && (!res_vld_q || res.ready);
	assign req.ready = !vld_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (req.ready)
			vld_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid)
			req_s1 <= req.data;
	end

	hgrp_parser #(
		.REQUEST_BYTES(REQUEST_BYTES),
		.PATH_BYTES   (PATH_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.req    (req_s1),
		.res_vld(core_vld),
		.res    (core_res)
	);

	// Result register: drop on transaction, load on a new result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= core_vld;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && core_vld)
			res_q <= core_res;
	end

	assign res.valid = res_vld_q;
	assign res.data  = res_q;

endmodule

/* tb/sv/tb_http_get_request_parser_top.sv */
module tb_http_get_request_parser_top;
	import hgrp_pkg::*;

	localparam int RB           = REQUEST_BYTES_DEF;
	localparam int PB           = PATH_BYTES_DEF;
	localparam int TARGET_ITEMS = 800;
	localparam int CYCLE_LIMIT  = 1_000_000;

	// One directed row: the byte, and a typed expectation where it is obvious
	typedef struct packed {
		req_t item;
		logic typed;
		logic has_res;
		res_t want;
	} row_t;

	localparam res_t BAD_EMPTY = '{KIND_VERDICT, 8'h00, STATUS_BAD, CT_PLAIN, 1'b0, 8'd0};
	localparam res_t NO_RES    = '0;

	localparam row_t DIR_ROWS [25] = '{
		'{'{"G", 1'b1}, 1'b1, 1'b1, BAD_EMPTY},
		'{'{8'hff, 1'b0}, 1'b1, 1'b1, BAD_EMPTY},
		'{'{CH_NUL, 1'b1}, 1'b1, 1'b0, NO_RES},
		'{'{CH_NUL, 1'b0}, 1'b1, 1'b1, BAD_EMPTY},
		'{'{"X", 1'b1}, 1'b1, 1'b0, NO_RES},
		'{'{"G", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"E", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"T", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{CH_SP, 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"/", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{CH_DOT, 1'b0}, 1'b0, 1'b0, NO_RES},
		'{'{"j", 1'b0}, 1'b0, 1'b0, NO_RES},
		'{'{"s", 1'b0}, 1'b0, 1'b0, NO_RES},
		'{'{CH_SP, 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"H", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"T", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"T", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"P", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"/", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"1", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{".", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{"0", 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{CH_CR, 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{CH_LF, 1'b0}, 1'b1, 1'b0, NO_RES},
		'{'{CH_LF, 1'b1}, 1'b0, 1'b0, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n;

	hgrp_stream_if #(.payload_t(req_t)) req_ch ();
	hgrp_stream_if #(.payload_t(res_t)) res_ch ();

	http_get_request_parser_top #(
		.REQUEST_BYTES(RB),
		.PATH_BYTES(PB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	always #10 clk = ~clk;

	// Parser mirror state
	stage_t      p_stage;
	int unsigned p_idx;
	logic [1:0]  p_ver;
	int unsigned p_term;
	logic        p_lf;
	int unsigned p_nbytes;
	int unsigned p_npath;
	logic [7:0]  p_ext [4];
	logic        p_dot;
	int unsigned p_extlen;
	logic        p_judged;

	string method_txt = "GET ";
	string v11_txt    = "HTTP/1.1";
	string v10_txt    = "HTTP/1.0";
	string ext_pool [14] = '{"html", "htm", "txt", "png", "jpg", "jpeg", "gif", "css", "js",
		"Htm", "jpegx", "", "x", "a/js"};
	string ver_pool [6] = '{"HTTP/1.1", "HTTP/1.0", "HTTP/1.2", "HTTP/1.", "HTTP/1.10",
		"HTTP/11"};

	res_t       verdict_q [$];
	logic [7:0] msg [$];
	logic       quiet;
	logic       src_calm;
	int         n_err = 0;
	int         n_cycles = 0;
	int         n_live = 0;
	int         n_sent = 0;
	int         n_msgs = 0;
	int         n_paths = 0;
	int         n_verdict [3] = '{0, 0, 0};

	function automatic void clear_parser();
		p_stage  = ST_METHOD;
		p_idx    = 0;
		p_ver    = 2'b11;
		p_term   = 0;
		p_lf     = 1'b0;
		p_nbytes = 0;
		p_npath  = 0;
		p_dot    = 1'b0;
		p_extlen = 0;
		p_judged = 1'b0;
		foreach (p_ext[i])
			p_ext[i] = 8'h00;
	endfunction

	// Classify the text after the last dot of the path
	function automatic logic [2:0] ext_type();
		logic [31:0] w;
		w = {p_ext[0], p_ext[1], p_ext[2], p_ext[3]};
		if (!p_dot)
			return CT_PLAIN;
		case (p_extlen)
			2: begin
				if (w[31:16] == "js")
					return CT_JS;
			end
			3: begin
				case (w[31:8])
					"htm":   return CT_HTML;
					"txt":   return CT_PLAIN;
					"png":   return CT_PNG;
					"jpg":   return CT_JPEG;
					"gif":   return CT_GIF;
					"css":   return CT_CSS;
					default: ;
				endcase
			end
			4: begin
				if (w == "html")
					return CT_HTML;
				if (w == "jpeg")
					return CT_JPEG;
			end
			default: ;
		endcase
		return CT_OCTET;
	endfunction

	function automatic res_t make_verdict(input logic [1:0] st);
		res_t r;
		r = '0;
		r.kind = KIND_VERDICT;
		r.status = st;
		if (st == STATUS_OK) begin
			if (p_npath == 0) begin
				r.default_index = 1'b1;
				r.content_type = CT_HTML;
			end else begin
				r.content_type = ext_type();
			end
		end
		r.path_length = 8'((p_npath < PB - 1) ? p_npath : PB - 1);
		p_judged = 1'b1;
		p_stage = ST_DONE;
		return r;
	endfunction

	// Advance the mirror by one byte; live is low when the byte is ignored
	function automatic void parse_byte(input req_t it, output logic made, output res_t r,
			output logic live);
		logic [7:0] b;
		logic       judge;
		logic [1:0] st;
		b = it.data_byte;
		made = 1'b0;
		r = '0;
		live = !p_judged;
		judge = 1'b0;
		st = STATUS_BAD;
		if (!p_judged) begin
			if (p_nbytes >= RB - 1 || b == CH_NUL) begin
				judge = 1'b1;
			end else begin
				case (p_stage)
					ST_METHOD: begin
						if (p_idx > 3 || b != method_txt[p_idx]) begin
							judge = 1'b1;
						end else begin
							p_idx++;
							if (p_idx == 4)
								p_stage = ST_URI_FIRST;
						end
					end
					ST_URI_FIRST: begin
						if (b == CH_SP || b == CH_CR || b == CH_LF)
							judge = 1'b1;
						else
							p_stage = ST_URI;
					end
					ST_URI: begin
						if (b == CH_SP) begin
							p_stage = ST_VERSION;
							p_idx = 0;
							p_ver = 2'b11;
						end else if (b == CH_CR || b == CH_LF) begin
							judge = 1'b1;
						end else if (p_npath < PB - 1) begin
							p_npath++;
							if (b == CH_DOT) begin
								p_dot = 1'b1;
								p_extlen = 0;
							end else if (p_dot) begin
								if (p_extlen < 4)
									p_ext[p_extlen] = b;
								if (p_extlen < 5)
									p_extlen++;
							end
							made = 1'b1;
							r.kind = KIND_PATH;
							r.path_byte = b;
						end else begin
							// drop the byte, remember the overflow
							p_npath = PB;
						end
					end
					ST_VERSION: begin
						if (p_idx >= 8) begin
							if (b == CH_CR) begin
								p_stage = ST_HEADER;
								p_term = 1;
								p_lf = 1'b0;
							end else begin
								judge = 1'b1;
							end
						end else begin
							if (b != v11_txt[p_idx])
								p_ver[0] = 1'b0;
							if (b != v10_txt[p_idx])
								p_ver[1] = 1'b0;
							if (p_ver == 2'b00)
								judge = 1'b1;
							else
								p_idx++;
						end
					end
					ST_HEADER: begin
						if (b == CH_LF) begin
							if (p_lf || p_term == 3) begin
								judge = 1'b1;
								st = (p_npath >= PB) ? STATUS_LONG : STATUS_OK;
							end else begin
								p_term = (p_term == 1) ? 2 : 0;
								p_lf = 1'b1;
							end
						end else if (b == CH_CR) begin
							p_term = (p_term == 2) ? 3 : 1;
							p_lf = 1'b0;
						end else begin
							p_term = 0;
							p_lf = 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (judge) begin
				r = make_verdict(st);
				made = 1'b1;
			end
			if (p_nbytes < RB)
				p_nbytes++;
		end
		// close the connection, with a verdict if none was given
		if (it.request_end) begin
			if (!p_judged) begin
				r = make_verdict(STATUS_BAD);
				made = 1'b1;
			end
			clear_parser();
		end
	endfunction

	function automatic void append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endfunction

	// Build one connection: mostly valid requests with random content, some noise
	function automatic void compose_request();
		int   plen;
		int   pick;
		int   cut;
		int   pos;
		logic lf_only;
		msg.delete();
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			repeat ($urandom_range(1, 8))
				msg.push_back(8'($urandom_range(0, 255)));
			return;
		end
		append_text("GET ");
		if (pick < 10)
			msg.push_back(CH_SP);
		else if (pick < 20)
			msg.push_back(8'($urandom_range(33, 126)));
		else
			msg.push_back("/");
		// path body; a few run past the path limit, some stay empty
		if (pick >= 88)
			plen = 0;
		else if ($urandom_range(0, 19) == 0)
			plen = $urandom_range(PB - 8, PB + 4);
		else
			plen = $urandom_range(0, 10);
		for (int i = 0; i < plen; i++) begin
			case ($urandom_range(0, 9))
				0:       msg.push_back("/");
				1:       msg.push_back(CH_DOT);
				2, 3:    msg.push_back(8'($urandom_range(33, 126)));
				default: msg.push_back(8'($urandom_range("a", "z")));
			endcase
		end
		if (pick < 88 && $urandom_range(0, 3) != 0) begin
			msg.push_back(CH_DOT);
			append_text(ext_pool[$urandom_range(0, 13)]);
		end
		msg.push_back(CH_SP);
		if ($urandom_range(0, 15) == 0)
			append_text(ver_pool[$urandom_range(2, 5)]);
		else
			append_text(ver_pool[$urandom_range(0, 1)]);
		msg.push_back(CH_CR);
		msg.push_back(CH_LF);
		// header lines, then the blank line
		lf_only = ($urandom_range(0, 2) == 0);
		repeat ($urandom_range(0, 2)) begin
			append_text("Host: ");
			repeat ($urandom_range(1, 6))
				msg.push_back(8'($urandom_range(32, 126)));
			if (!lf_only)
				msg.push_back(CH_CR);
			msg.push_back(CH_LF);
		end
		if (!lf_only)
			msg.push_back(CH_CR);
		msg.push_back(CH_LF);
		repeat ($urandom_range(0, 3))
			msg.push_back(8'($urandom_range(0, 255)));
		// break some requests: overwrite one byte or cut the connection short
		if ($urandom_range(0, 7) == 0) begin
			pos = $urandom_range(0, msg.size() - 1);
			case ($urandom_range(0, 4))
				0:       msg[pos] = CH_NUL;
				1:       msg[pos] = CH_CR;
				2:       msg[pos] = CH_LF;
				3:       msg[pos] = CH_SP;
				default: msg[pos] = 8'($urandom_range(0, 255));
			endcase
		end
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, msg.size());
			msg = msg[0:cut-1];
		end
	endfunction

	// Drive one transaction, then predict what it causes
	task automatic put_byte(input req_t it, input logic typed, input logic has_res,
			input res_t want);
		logic made;
		logic live;
		res_t r;
		if (!quiet && !src_calm && $urandom_range(0, 9) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		parse_byte(it, made, r, live);
		if (typed) begin
			made = has_res;
			r = want;
		end
		if (made) begin
			verdict_q.push_back(r);
			if (r.kind == KIND_PATH)
				n_paths++;
			else
				n_verdict[r.status]++;
		end
		if (live)
			n_live++;
		n_sent++;
	endtask

	task automatic send_msg();
		req_t it;
		src_calm = ($urandom_range(0, 3) == 0);
		foreach (msg[i]) begin
			it.data_byte = msg[i];
			it.request_end = (i == msg.size() - 1);
			put_byte(it, 1'b0, 1'b0, NO_RES);
		end
		n_msgs++;
	endtask

	// Hold the sender until every expected result is back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic void cmp_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			n_err++;
		end
	endfunction

	task automatic check_result(input res_t got);
		res_t want;
		if (verdict_q.size() == 0) begin
			$display("%0t: result with nothing expected, got %p", $time, got);
			n_err++;
		end else begin
			want = verdict_q.pop_front();
			cmp_field("kind", want.kind, got.kind);
			cmp_field("path_byte", want.path_byte, got.path_byte);
			cmp_field("status", want.status, got.status);
			cmp_field("content_type", want.content_type, got.content_type);
			cmp_field("default_index", want.default_index, got.default_index);
			cmp_field("path_length", want.path_length, got.path_length);
		end
	endtask

	// Stimulus: directed rows, then random connections, then drain
	initial begin
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		quiet = 1'b0;
		src_calm = 1'b0;
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIR_ROWS[i])
			put_byte(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].has_res, DIR_ROWS[i].want);
		while (n_sent < TARGET_ITEMS) begin
			if (n_msgs == 5)
				wait_drained();
			compose_request();
			send_msg();
			if (!quiet && $urandom_range(0, 24) == 0)
				wait_drained();
			if (n_sent >= TARGET_ITEMS - 100)
				quiet = 1'b1;
		end
		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d connections, %0d bytes (%0d before a verdict); %0d path bytes, %0d verdicts",
			n_msgs, n_sent, n_live, n_paths, n_verdict[0] + n_verdict[1] + n_verdict[2]);
		$display("Verdicts: ok %0d, bad request %0d, path too long %0d",
			n_verdict[0], n_verdict[1], n_verdict[2]);
		if (n_err == 0)
			$display("PASS http_get_request_parser_top");
		else
			$display("FAIL http_get_request_parser_top");
		$finish;
	end

	// Result side: check each transaction, stall in random bursts
	initial begin
		int hold;
		int calm;
		hold = 0;
		calm = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				check_result(res_ch.data);
			if (quiet) begin
				res_ch.ready <= 1'b1;
			end else if (hold > 0) begin
				res_ch.ready <= 1'b0;
				hold--;
			end else if (calm > 0) begin
				res_ch.ready <= 1'b1;
				calm--;
			end else begin
				case ($urandom_range(0, 15))
					0: begin
						res_ch.ready <= 1'b0;
						hold = $urandom_range(0, 13);
					end
					1: begin
						res_ch.ready <= 1'b1;
						calm = $urandom_range(20, 100);
					end
					default: res_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, n_cycles);
			$display("FAIL http_get_request_parser_top");
			$finish;
		end
	end

endmodule
